// ----- design/cfe_pkg.sv -----
// Shared types and constants for the COBS frame encoder.
package cfe_pkg;

  localparam int unsigned SEGMENT_MAX = 61;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned BYTE_W      = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_CODE,
    ST_DATA,
    ST_ONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_HDR,
    SEL_CODE,
    SEL_DATA,
    SEL_ONE
  } sel_t;

  typedef struct packed {
    logic accept;
    logic load;
    sel_t sel;
    logic run_last;
    logic frame_end;
    logic seg_clr;
    logic frame_clr;
    logic hdr_set;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    logic in_zero;
    logic in_last;
    logic lat_zero;
    logic lat_last;
    logic hdr_sent;
    logic cnt_zero;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

// ----- design/cobs_frame_encoder.sv -----
// Top level of the COBS frame encoder: sequencer plus datapath.
//
// Input stream: one payload byte per item on in_tdata, in_tlast marks the
// final byte of a frame. Output stream: encoded bytes on out_tdata, out_tlast
// on the final byte of the encoded frame, out_tuser carries the per-item
// run-last mark and the overflow flag.
// The first item of a frame produces a zero header byte. A zero byte, or the
// last byte of the frame, closes the open segment: a code byte (held count
// plus one) follows, then the held bytes; a trailing zero adds a code of 1.
// A nonzero byte beyond 61 held bytes is dropped and flagged on the flush.
// Timing: an item that produces no output leaves the sequencer in idle. Otherwise
// the block accepts it in idle, then emits one byte per cycle into the
// output register while the receiver does not stall; the single sequencer and
// the one-byte-wide output register set this rate.
// The first result is loaded from the header or code state that follows acceptance.
// When the receiver stalls, the output register holds and the sequencer
// waits; no input is taken until all results of the item are loaded.
// Reset (rst_n low, synchronous) clears the sequencer, counters and the
// header flag; the store contents need no reset.
module cobs_frame_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic [1:0] out_tuser   // [0] run_last, [1] overflow
);

  cfe_pkg::cmd_t    cmd;
  cfe_pkg::status_t st;

  cfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  cfe_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .st         (st)
  );

`ifndef SYNTH
  a_frame_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("frame end without run-last mark");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_tvalid || out_tready))
    else $error("output register overwritten while stalled");

  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !cmd.load)
    else $error("item accepted during emission");

  a_zero_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata == 8'd0) |=> !in_tready)
    else $error("zero byte did not start a segment flush");
`endif

endmodule

// ----- design/cfe_ctrl.sv -----
// Sequencer for the COBS frame encoder: header, code byte, held bytes, trailing code.
module cfe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  cfe_pkg::status_t st,
  output cfe_pkg::cmd_t    cmd
);

  cfe_pkg::state_t state_r, state_nxt;
  logic            close_seg;
  logic            tail_one;

  assign close_seg = st.lat_zero | st.lat_last;
  assign tail_one  = st.lat_zero & st.lat_last;
  assign in_tready = (state_r == cfe_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfe_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (!st.hdr_sent) begin
            state_nxt = cfe_pkg::ST_HDR;
          end else if (st.in_zero || st.in_last) begin
            state_nxt = cfe_pkg::ST_CODE;
          end
        end
      end
      cfe_pkg::ST_HDR: begin
        if (st.out_free) begin
          state_nxt = close_seg ? cfe_pkg::ST_CODE : cfe_pkg::ST_IDLE;
        end
      end
      cfe_pkg::ST_CODE: begin
        if (st.out_free) begin
          if (!st.cnt_zero) begin
            state_nxt = cfe_pkg::ST_DATA;
          end else begin
            state_nxt = tail_one ? cfe_pkg::ST_ONE : cfe_pkg::ST_IDLE;
          end
        end
      end
      cfe_pkg::ST_DATA: begin
        if (st.out_free && st.idx_last) begin
          state_nxt = tail_one ? cfe_pkg::ST_ONE : cfe_pkg::ST_IDLE;
        end
      end
      cfe_pkg::ST_ONE: begin
        if (st.out_free) begin
          state_nxt = cfe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cfe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.sel       = cfe_pkg::SEL_HDR;
    cmd.accept    = in_tvalid && (state_r == cfe_pkg::ST_IDLE);
    unique case (state_r)
      cfe_pkg::ST_IDLE: begin
      end
      cfe_pkg::ST_HDR: begin
        cmd.load     = st.out_free;
        cmd.sel      = cfe_pkg::SEL_HDR;
        cmd.run_last = !close_seg;
        cmd.hdr_set  = st.out_free;
      end
      cfe_pkg::ST_CODE: begin
        cmd.load      = st.out_free;
        cmd.sel       = cfe_pkg::SEL_CODE;
        cmd.run_last  = st.cnt_zero && !tail_one;
        cmd.frame_end = st.cnt_zero && !tail_one && st.lat_last;
        cmd.seg_clr   = st.out_free && st.cnt_zero;
        cmd.frame_clr = st.out_free && st.cnt_zero && st.lat_last && !tail_one;
      end
      cfe_pkg::ST_DATA: begin
        cmd.load      = st.out_free;
        cmd.sel       = cfe_pkg::SEL_DATA;
        cmd.run_last  = st.idx_last && !tail_one;
        cmd.frame_end = st.idx_last && !tail_one && st.lat_last;
        cmd.idx_inc   = st.out_free;
        cmd.seg_clr   = st.out_free && st.idx_last;
        cmd.frame_clr = st.out_free && st.idx_last && st.lat_last && !tail_one;
      end
      cfe_pkg::ST_ONE: begin
        cmd.load      = st.out_free;
        cmd.sel       = cfe_pkg::SEL_ONE;
        cmd.run_last  = 1'b1;
        cmd.frame_end = 1'b1;
        cmd.frame_clr = st.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/cfe_datapath.sv -----
// Segment store, counters, frame flags and output register of the COBS frame encoder.
module cfe_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cfe_pkg::BYTE_W-1:0]    in_tdata,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cfe_pkg::BYTE_W-1:0]    out_tdata,
  output logic                          out_tlast,
  output logic [1:0]                    out_tuser,
  input  cfe_pkg::cmd_t                 cmd,
  output cfe_pkg::status_t              st
);

  logic [cfe_pkg::BYTE_W-1:0] seg_mem [cfe_pkg::SEGMENT_MAX];
  logic [cfe_pkg::BYTE_W-1:0] rd_data_r;
  logic [cfe_pkg::CNT_W-1:0]  rd_addr;

  logic [cfe_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [cfe_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic                       dropped_r, dropped_nxt;
  logic                       hdr_sent_r, hdr_sent_nxt;
  logic                       lat_zero_r, lat_last_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [cfe_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                       run_last_r, frame_end_r, ovf_r, ovf_nxt;

  logic                       in_zero;
  logic                       cnt_full;
  logic                       store_wr;

  assign in_zero  = (in_tdata == '0);
  assign cnt_full = (cnt_r >= cfe_pkg::CNT_W'(cfe_pkg::SEGMENT_MAX));
  assign store_wr = cmd.accept && !in_zero && !cnt_full;

  assign st.in_zero  = in_zero;
  assign st.in_last  = in_tlast;
  assign st.lat_zero = lat_zero_r;
  assign st.lat_last = lat_last_r;
  assign st.hdr_sent = hdr_sent_r;
  assign st.cnt_zero = (cnt_r == '0);
  assign st.idx_last = (idx_r == cnt_r - cfe_pkg::CNT_W'(1));
  assign st.out_free = !out_valid_r || out_tready;

  // read one entry ahead while the current held byte goes out
  assign rd_addr = (cmd.idx_inc && !st.idx_last) ? idx_r + cfe_pkg::CNT_W'(1) : idx_r;

  always_ff @(posedge clk) begin
    if (store_wr) begin
      seg_mem[cnt_r] <= in_tdata;
    end
    rd_data_r <= seg_mem[rd_addr];
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    dropped_nxt  = dropped_r;
    hdr_sent_nxt = hdr_sent_r;
    idx_nxt      = idx_r;
    if (cmd.accept && !in_zero) begin
      if (cnt_full) begin
        dropped_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + cfe_pkg::CNT_W'(1);
      end
    end
    if (cmd.idx_inc) begin
      idx_nxt = idx_r + cfe_pkg::CNT_W'(1);
    end
    if (cmd.hdr_set) begin
      hdr_sent_nxt = 1'b1;
    end
    if (cmd.seg_clr) begin
      cnt_nxt     = '0;
      dropped_nxt = 1'b0;
      idx_nxt     = '0;
    end
    if (cmd.frame_clr) begin
      cnt_nxt      = '0;
      dropped_nxt  = 1'b0;
      idx_nxt      = '0;
      hdr_sent_nxt = 1'b0;
    end
  end

  always_comb begin
    out_byte_nxt = '0;
    ovf_nxt      = 1'b0;
    unique case (cmd.sel)
      cfe_pkg::SEL_HDR: begin
        out_byte_nxt = '0;
      end
      cfe_pkg::SEL_CODE: begin
        out_byte_nxt = cfe_pkg::BYTE_W'(cnt_r) + cfe_pkg::BYTE_W'(1);
        ovf_nxt      = dropped_r;
      end
      cfe_pkg::SEL_DATA: begin
        out_byte_nxt = rd_data_r;
        ovf_nxt      = dropped_r;
      end
      cfe_pkg::SEL_ONE: begin
        out_byte_nxt = cfe_pkg::BYTE_W'(1);
      end
      default: out_byte_nxt = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      dropped_r   <= 1'b0;
      hdr_sent_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      dropped_r   <= dropped_nxt;
      hdr_sent_r  <= hdr_sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lat_zero_r <= in_zero;
      lat_last_r <= in_tlast;
    end
    if (cmd.load) begin
      out_byte_r  <= out_byte_nxt;
      run_last_r  <= cmd.run_last;
      frame_end_r <= cmd.frame_end;
      ovf_r       <= ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = frame_end_r;
  assign out_tuser  = {ovf_r, run_last_r};

endmodule

// ----- verif/cobs_frame_encoder_tb.sv -----
// Self-checking testbench for the COBS frame encoder: directed and random frames.
module cobs_frame_encoder_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_ITEMS  = 96;

  typedef struct packed {
    logic [cfe_pkg::BYTE_W-1:0] data;
    logic                       run_last;
    logic                       frame_end;
    logic                       overflow;
  } enc_item_t;

  class cobs_scoreboard;
    enc_item_t                  enc_q[$];
    logic [cfe_pkg::BYTE_W-1:0] seg_buf[cfe_pkg::SEGMENT_MAX];
    logic [cfe_pkg::CNT_W-1:0]  seg_len;
    bit                         hdr_done;
    bit                         seg_lost;
    int unsigned                err_count;
    int unsigned                in_count;
    int unsigned                out_count;
    int unsigned                frame_count;
    int unsigned                ovf_count;

    function new();
      seg_len  = '0;
      hdr_done = 1'b0;
      seg_lost = 1'b0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      err_count++;
    endtask

    function void flush_seg(ref enc_item_t res[$]);
      enc_item_t r;
      r = '{data: cfe_pkg::BYTE_W'(seg_len) + 8'd1, run_last: 1'b0, frame_end: 1'b0,
            overflow: seg_lost};
      res.push_back(r);
      for (int i = 0; i < int'(seg_len); i++) begin
        r.data = seg_buf[i];
        res.push_back(r);
      end
      seg_len  = '0;
      seg_lost = 1'b0;
    endfunction

    function void note_input(logic [cfe_pkg::BYTE_W-1:0] d, logic last);
      enc_item_t res[$];
      enc_item_t r;
      in_count++;
      if (!hdr_done) begin
        r = '{data: 8'd0, run_last: 1'b0, frame_end: 1'b0, overflow: 1'b0};
        res.push_back(r);
        hdr_done = 1'b1;
      end
      if (d == 8'd0) begin
        flush_seg(res);
        if (last) begin
          r = '{data: 8'd1, run_last: 1'b0, frame_end: 1'b0, overflow: 1'b0};
          res.push_back(r);
        end
      end else begin
        if (seg_len < cfe_pkg::SEGMENT_MAX) begin
          seg_buf[seg_len] = d;
          seg_len++;
        end else begin
          seg_lost = 1'b1;
        end
        if (last) flush_seg(res);
      end
      if (res.size() > 0) begin
        res[res.size()-1].run_last = 1'b1;
        if (last) res[res.size()-1].frame_end = 1'b1;
      end
      if (last) begin
        seg_len  = '0;
        hdr_done = 1'b0;
        seg_lost = 1'b0;
        frame_count++;
      end
      foreach (res[i]) enc_q.push_back(res[i]);
    endfunction

    task check_result(logic [cfe_pkg::BYTE_W-1:0] d, logic rl, logic fe, logic ov);
      enc_item_t e;
      out_count++;
      if (ov) ovf_count++;
      if (enc_q.size() == 0) begin
        report($sformatf("unexpected item data=%02h", d));
        return;
      end
      e = enc_q.pop_front();
      if (d !== e.data)
        report($sformatf("item %0d data %02h, want %02h", out_count, d, e.data));
      if (rl !== e.run_last)
        report($sformatf("item %0d run_last %b, want %b", out_count, rl, e.run_last));
      if (fe !== e.frame_end)
        report($sformatf("item %0d frame_end %b, want %b", out_count, fe, e.frame_end));
      if (ov !== e.overflow)
        report($sformatf("item %0d overflow %b, want %b", out_count, ov, e.overflow));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;
  logic              out_tlast;
  logic [1:0]        out_tuser;

  cobs_scoreboard    sb;
  bit                calm;
  int unsigned       cycle_count;

  cobs_frame_encoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[cobs_frame_encoder] ERROR");
      $finish;
    end
  end

  // receiver: check accepted items, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser[0], out_tlast, out_tuser[1]);
    out_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 14);
  end

  task automatic send_item(logic [7:0] d, logic last);
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_input(d, last);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.enc_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_frame(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_item(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic random_frame(bit force_long, ref int unsigned sent);
    logic [7:0] bytes[$];
    int unsigned len;
    int unsigned zero_pct;
    bit          long_run;
    long_run = force_long || ($urandom_range(0, 9) < 2);
    if (long_run) begin
      len      = force_long ? $urandom_range(62, 66) : $urandom_range(58, 66);
      zero_pct = force_long ? 0 : 2;
    end else begin
      len      = $urandom_range(1, 10);
      zero_pct = 30;
    end
    for (int i = 0; i < int'(len); i++) begin
      if ($urandom_range(0, 99) < zero_pct) bytes.push_back(8'd0);
      else bytes.push_back(8'($urandom_range(1, 255)));
    end
    send_frame(bytes);
    sent += len;
  endtask

  initial begin
    int unsigned sent;
    bit          paused;
    sb          = new();
    calm        = 1'b0;
    cycle_count = 0;
    sent        = 0;
    paused      = 1'b0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 8'd0;
    in_tlast   <= 1'b0;
    out_tready <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames: lone zero, lone byte, extremes, zero runs, trailing zero
    send_frame('{8'h00});
    send_frame('{8'hFF});
    send_frame('{8'h01, 8'h80, 8'h00, 8'h7F});
    send_frame('{8'h00, 8'h00, 8'hFF, 8'h00});
    send_frame('{8'h55, 8'hAA, 8'h00, 8'h00});
    send_frame('{8'hFE, 8'h01, 8'h00, 8'h02, 8'hFD});
    send_frame('{8'h00, 8'h40});
    drain();

    // random frames; first one overruns the segment store
    random_frame(1'b1, sent);
    while (sent < RAND_ITEMS) begin
      calm = (sent >= 40 && sent < 80);
      random_frame(1'b0, sent);
      if (!paused && sent >= 60) begin
        drain();
        paused = 1'b1;
      end
    end
    calm = 1'b0;
    drain();
    repeat (10) @(posedge clk);

    $display("covered %0d frames, %0d input items, %0d encoded items (%0d with overflow)",
             sb.frame_count, sb.in_count, sb.out_count, sb.ovf_count);
    if (sb.err_count == 0 && sb.enc_q.size() == 0) begin
      $display("[cobs_frame_encoder] OK");
    end else begin
      $display("%0d mismatches, %0d items still expected", sb.err_count, sb.enc_q.size());
      $display("[cobs_frame_encoder] ERROR");
    end
    $finish;
  end

endmodule
